// ===== hdl/fuzzy_position_controller_core_assert.svh =====
// Assertion macros shared by the fuzzy position controller RTL.
// Each macro expands to one labeled concurrent assertion that is
// disabled while the synchronous reset is active.
`ifndef FUZZY_POSITION_CONTROLLER_CORE_ASSERT_SVH
`define FUZZY_POSITION_CONTROLLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpc assertion failed");

`endif

// ===== hdl/fpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants of the fuzzy position controller.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // Membership fractions: 16 bits, all ones stands for 1.0.
    localparam int          MEM_W      = 16;
    localparam logic [15:0] FULL_SCALE = 16'hFFFF;

    // Shared divider sizing.
    localparam int          DIVIS_W    = 35;
    localparam int          QUO_W      = 16;
    localparam int          STEP_W     = 5;
    localparam logic [4:0]  FRAC_STEPS = 5'd16;
    localparam logic [4:0]  QUO_STEPS  = 5'd10;

    // Configuration port.
    localparam int          CFG_IDX_W  = 3;
    localparam int          CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS_PER_UPDATE = 3'd0,
        REG_ERROR_INNER      = 3'd1,
        REG_ERROR_OUTER      = 3'd2,
        REG_RATE_INNER       = 3'd3,
        REG_RATE_OUTER       = 3'd4,
        REG_DRIVE_INNER      = 3'd5,
        REG_DRIVE_OUTER      = 3'd6,
        REG_DUTY_LIMIT       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  ticks_per_update;
        logic [14:0] error_inner;
        logic [14:0] error_outer;
        logic [19:0] rate_inner;
        logic [19:0] rate_outer;
        logic [9:0]  drive_inner;
        logic [9:0]  drive_outer;
        logic [9:0]  duty_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ticks_per_update: 8'd10,
        error_inner:      15'd10,
        error_outer:      15'd300,
        rate_inner:       20'd200,
        rate_outer:       20'd400,
        drive_inner:      10'd150,
        drive_outer:      10'd500,
        duty_limit:       10'd800
    };

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

// ===== hdl/fpc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_in_if
// Tick channel: setpoint and encoder position with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] setpoint;
    logic signed [15:0] position;

    modport source (output valid, output setpoint, output position, input ready);
    modport sink   (input valid, input setpoint, input position, output ready);
endinterface

// ===== hdl/fpc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_out_if
// Result channel: duty, direction and control value with valid/ready.
// ----------------------------------------------------------------------------
interface fpc_out_if;
    logic               valid;
    logic               ready;
    logic        [9:0]  duty;
    logic               forward;
    logic signed [10:0] control_value;

    modport source (output valid, output duty, output forward, output control_value,
                    input ready);
    modport sink   (input valid, input duty, input forward, input control_value,
                    output ready);
endinterface

// ===== hdl/fpc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module fpc_cfg_regs
    import fpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Decode the index and update the addressed field.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TICKS_PER_UPDATE: r_cfg.ticks_per_update <= i_cfg_data[7:0];
                REG_ERROR_INNER:      r_cfg.error_inner      <= i_cfg_data[14:0];
                REG_ERROR_OUTER:      r_cfg.error_outer      <= i_cfg_data[14:0];
                REG_RATE_INNER:       r_cfg.rate_inner       <= i_cfg_data[19:0];
                REG_RATE_OUTER:       r_cfg.rate_outer       <= i_cfg_data[19:0];
                REG_DRIVE_INNER:      r_cfg.drive_inner      <= i_cfg_data[9:0];
                REG_DRIVE_OUTER:      r_cfg.drive_outer      <= i_cfg_data[9:0];
                REG_DUTY_LIMIT:       r_cfg.duty_limit       <= i_cfg_data[9:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/fpc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_divider
// Shared restoring divider, one quotient bit per cycle. The caller loads a
// partial remainder below the divisor and the low dividend bits MSB first.
// ----------------------------------------------------------------------------
module fpc_divider
    import fpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    input  logic [DIVIS_W-1:0] i_rem,
    input  logic [QUO_W-1:0]   i_low,
    input  logic [DIVIS_W-1:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [QUO_W-1:0]   o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIVIS_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_low;
    logic [DIVIS_W-1:0] r_div;
    logic [QUO_W-1:0]  r_quo;

    logic [DIVIS_W:0]  w_trial;
    logic [DIVIS_W:0]  w_diff;
    logic              w_fits;

    // Shift in the next dividend bit and try a subtraction.
    assign w_trial = {r_rem, r_low[QUO_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    // Step counter and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_rem;
            r_low <= i_low;
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DIVIS_W-1:0] : w_trial[DIVIS_W-1:0];
            r_low <= {r_low[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_fits};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/fuzzy_position_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_position_controller_core
// Fuzzy PD position controller with a 3x3 rule base, run by a small sequencer
// around one shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
// Each request on i_in is one control tick with a setpoint and an encoder
// position. Every ticks_per_update-th tick runs a control update and yields
// one request on o_out (duty, forward, control_value); other ticks yield none.
// A tick that does not update is absorbed and leaves the block idle. An input
// that saturates its sets needs no division; otherwise error and derivative
// each need two 16-step divisions on the shared divider for their
// memberships. Then come two shared multiplies and, for a nonzero weight
// sum, a 10-step division for the weighted average. i_in.ready is low for the
// whole update. A finished result waits in the output register; while the
// receiver stalls, a new tick is still accepted, and the next update holds in
// its last step until the output register is free. Configuration is written
// through i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle. Reset clears
// the tick count, the stored error and the output valid, and loads the
// register defaults.
// ----------------------------------------------------------------------------
`include "fuzzy_position_controller_core_assert.svh"

module fuzzy_position_controller_core
    import fpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fpc_in_if.sink                i_in,
    fpc_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DER, S_FUZ, S_DIVA, S_DIVB, S_RULE,
        S_MUL1, S_MUL2, S_QDIV, S_QWAIT, S_OUT
    } t_state;

    function automatic logic [15:0] fmin(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [15:0] fmax(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? a : b;
    endfunction

    t_cfg               r_cfg;
    t_state             r_state;
    logic [7:0]         r_tick;
    logic signed [16:0] r_last;
    logic signed [16:0] r_err;
    logic signed [24:0] r_der;
    logic [23:0]        r_ax;
    logic               r_neg;
    logic               r_pos;
    logic               r_phase;
    logic [15:0]        r_side;
    logic [15:0]        r_mn [2];
    logic [15:0]        r_mz [2];
    logic [15:0]        r_mp [2];
    logic [15:0]        r_r;
    logic               r_fwd;
    logic [17:0]        r_den;
    logic [42:0]        r_prod;
    logic [9:0]         r_mag;
    logic               r_out_valid;
    logic [9:0]         r_out_duty;
    logic               r_out_fwd;
    logic [10:0]        r_out_cv;

    logic [8:0]         w_tick_next;
    logic               w_update;
    logic signed [16:0] w_err;
    logic [17:0]        w_diff;
    logic [24:0]        w_diff_ext;
    logic [24:0]        w_der;
    logic [16:0]        w_err_abs;
    logic [24:0]        w_der_abs;
    logic [19:0]        w_inner;
    logic               w_ax_ge;
    logic [19:0]        w_frac_num;
    logic [35:0]        w_scaled;
    logic [34:0]        w_qdivisor;
    logic [15:0]        w_rn;
    logic [15:0]        w_rz;
    logic [15:0]        w_rp;
    logic [26:0]        w_o_fs;
    logic [26:0]        w_mul_b;
    logic [42:0]        w_mul;
    t_div_req           w_div_req;
    logic [DIVIS_W-1:0] w_div_rem;
    logic [QUO_W-1:0]   w_div_low;
    logic [DIVIS_W-1:0] w_div_divisor;
    logic               w_div_busy;
    logic               w_div_done;
    logic [QUO_W-1:0]   w_div_quo;
    logic               w_out_load;
    logic               w_in_take;
    logic               w_div_wait;
    logic               w_cv_pos;

    // Configuration registers.
    fpc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (r_cfg)
    );

    // Tick divider decision.
    assign w_tick_next = {1'b0, r_tick} + 9'd1;
    assign w_update    = w_tick_next >= {1'b0, r_cfg.ticks_per_update};

    // Error, and derivative as 100 times the error change (64 + 32 + 4).
    assign w_err      = {i_in.setpoint[15], i_in.setpoint} - {i_in.position[15], i_in.position};
    assign w_diff     = {r_err[16], r_err} - {r_last[16], r_last};
    assign w_diff_ext = {{7{w_diff[17]}}, w_diff};
    assign w_der      = (w_diff_ext << 6) + (w_diff_ext << 5) + (w_diff_ext << 2);
    assign w_err_abs  = r_err[16] ? (17'd0 - r_err) : r_err;
    assign w_der_abs  = r_der[24] ? (25'd0 - r_der) : r_der;

    // Fuzzification operands for the variable in work.
    assign w_inner    = r_phase ? r_cfg.rate_inner : {5'd0, r_cfg.error_inner};
    assign w_ax_ge    = r_ax >= {4'd0, w_inner};
    assign w_frac_num = (r_state == S_FUZ) ? r_ax[19:0] : (w_inner - r_ax[19:0]);
    assign w_scaled   = {w_frac_num, 16'd0} - {16'd0, w_frac_num};

    // Weighted-average divisor: 2 * full scale * weight sum.
    assign w_qdivisor = ({17'd0, r_den} << 17) - ({17'd0, r_den} << 1);

    // Rule base: min for AND, max for OR.
    assign w_rn = fmax(fmin(r_mn[1], r_mn[0]), fmin(r_mz[1], r_mn[0]));
    assign w_rz = fmax(fmax(fmax(fmin(r_mp[1], r_mn[0]), fmin(r_mn[1], r_mz[0])),
                            fmax(fmin(r_mz[1], r_mz[0]), fmin(r_mp[1], r_mz[0]))),
                       fmin(r_mn[1], r_mp[0]));
    assign w_rp = fmax(fmin(r_mz[1], r_mp[0]), fmin(r_mp[1], r_mp[0]));

    // Shared multiplier: strength times inner breakpoint, then strength
    // times (that product plus outer breakpoint times full scale).
    assign w_o_fs  = ({17'd0, r_cfg.drive_outer} << 16) - {17'd0, r_cfg.drive_outer};
    assign w_mul_b = (r_state == S_MUL2) ? ({1'b0, r_prod[25:0]} + w_o_fs)
                                         : {17'd0, r_cfg.drive_inner};
    assign w_mul   = {27'd0, r_r} * {16'd0, w_mul_b};

    // The finished result moves to the output register once it is free.
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // Divider requests and operand selection.
    always_comb begin
        w_div_req.start = ((r_state == S_FUZ) && !w_ax_ge)
                       || ((r_state == S_DIVA) && w_div_done)
                       || ((r_state == S_QDIV) && (r_den != 18'd0));
        w_div_req.steps = (r_state == S_QDIV) ? QUO_STEPS : FRAC_STEPS;
        if (r_state == S_QDIV) begin
            w_div_rem     = {2'd0, r_prod[42:10]};
            w_div_low     = {r_prod[9:0], 6'd0};
            w_div_divisor = w_qdivisor;
        end else begin
            w_div_rem     = {15'd0, w_scaled[35:16]};
            w_div_low     = w_scaled[15:0];
            w_div_divisor = {15'd0, w_inner};
        end
    end

    fpc_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_rem     (w_div_rem),
        .i_low     (w_div_low),
        .i_divisor (w_div_divisor),
        .o_busy    (w_div_busy),
        .o_done    (w_div_done),
        .o_quo     (w_div_quo)
    );

    // Sequencer with its datapath and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_last      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (w_update) begin
                            r_tick  <= '0;
                            r_err   <= w_err;
                            r_state <= S_DER;
                        end else begin
                            r_tick <= w_tick_next[7:0];
                        end
                    end
                end
                S_DER: begin
                    r_der   <= signed'(w_der);
                    r_last  <= r_err;
                    r_ax    <= {7'd0, w_err_abs};
                    r_neg   <= r_err[16];
                    r_pos   <= !r_err[16] && (r_err != 17'sd0);
                    r_phase <= 1'b0;
                    r_state <= S_FUZ;
                end
                S_FUZ: begin
                    // A saturated input needs no division.
                    if (w_ax_ge) begin
                        r_mn[r_phase] <= r_neg ? FULL_SCALE : 16'd0;
                        r_mz[r_phase] <= 16'd0;
                        r_mp[r_phase] <= r_pos ? FULL_SCALE : 16'd0;
                        if (r_phase) begin
                            r_state <= S_RULE;
                        end else begin
                            r_ax    <= w_der_abs[23:0];
                            r_neg   <= r_der[24];
                            r_pos   <= !r_der[24] && (r_der != 25'sd0);
                            r_phase <= 1'b1;
                        end
                    end else begin
                        r_state <= S_DIVA;
                    end
                end
                S_DIVA: begin
                    if (w_div_done) begin
                        r_side  <= w_div_quo;
                        r_state <= S_DIVB;
                    end
                end
                S_DIVB: begin
                    if (w_div_done) begin
                        r_mn[r_phase] <= r_neg ? r_side : 16'd0;
                        r_mz[r_phase] <= w_div_quo;
                        r_mp[r_phase] <= r_pos ? r_side : 16'd0;
                        if (r_phase) begin
                            r_state <= S_RULE;
                        end else begin
                            r_ax    <= w_der_abs[23:0];
                            r_neg   <= r_der[24];
                            r_pos   <= !r_der[24] && (r_der != 25'sd0);
                            r_phase <= 1'b1;
                            r_state <= S_FUZ;
                        end
                    end
                end
                S_RULE: begin
                    // Negative and positive strengths never both hold.
                    r_r     <= w_rn | w_rp;
                    r_fwd   <= w_rp != 16'd0;
                    r_den   <= {2'd0, w_rn} + {2'd0, w_rz} + {2'd0, w_rp};
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_prod  <= w_mul;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= w_mul;
                    r_state <= S_QDIV;
                end
                S_QDIV: begin
                    if (r_den == 18'd0) begin
                        r_mag   <= '0;
                        r_fwd   <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_QWAIT;
                    end
                end
                S_QWAIT: begin
                    if (w_div_done) begin
                        r_mag   <= w_div_quo[9:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_duty  <= (r_mag > r_cfg.duty_limit) ? r_cfg.duty_limit : r_mag;
                        r_out_fwd   <= r_fwd && (r_mag != 10'd0);
                        r_out_cv    <= r_fwd ? {1'b0, r_mag} : (11'd0 - {1'b0, r_mag});
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Port drive.
    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.duty          = r_out_duty;
    assign o_out.forward       = r_out_fwd;
    assign o_out.control_value = signed'(r_out_cv);

    // Terms used by the checks below.
    assign w_in_take  = i_in.valid && i_in.ready;
    assign w_div_wait = (r_state == S_DIVA) || (r_state == S_DIVB) || (r_state == S_QWAIT);
    assign w_cv_pos   = !r_out_cv[10] && (r_out_cv != 11'd0);

    // A tick that does not update leaves the block ready.
    `FPC_ASSERT_NEXT(a_skip_tick_idle, i_clk, i_rst_n, w_in_take && !w_update, r_state == S_IDLE)
    // Forward direction only with a positive control value.
    `FPC_ASSERT_NOW(a_forward_sign, i_clk, i_rst_n, o_out.valid && o_out.forward, w_cv_pos)
    // The duty never exceeds its limit.
    `FPC_ASSERT_NOW(a_duty_limit, i_clk, i_rst_n, o_out.valid, o_out.duty <= r_cfg.duty_limit)
    // Divider results arrive only while the sequencer waits for them.
    `FPC_ASSERT_NOW(a_div_done_wait, i_clk, i_rst_n, w_div_done, w_div_wait)
    // The divider is never restarted while it runs.
    `FPC_ASSERT_NOW(a_div_no_overlap, i_clk, i_rst_n, w_div_req.start, !w_div_busy)

endmodule

// ===== tb/fuzzy_position_controller_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_position_controller_core_tb
// Self-checking bench for the fuzzy PD position controller. Ticks are sent on
// the input channel from a queue, a cycle-free model of the tick counter and
// the fuzzy update predicts each control result, and a monitor compares every
// result request on the output channel with the oldest prediction. Register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module fuzzy_position_controller_core_tb;
    import fpc_pkg::*;

    localparam int     HALF_PERIOD   = 6;
    localparam int     SETTLE_CYCLES = 150;
    localparam int     LONG_HOLD     = 400;
    localparam longint TIMEOUT_NS    = 64'd24_000_000;
    localparam longint FULL          = longint'(FULL_SCALE);

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] position;
    } t_tick;

    typedef struct packed {
        logic [9:0]         duty;
        logic               forward;
        logic signed [10:0] control_value;
    } t_drive;

    // Bench-side drive of the block's inputs; all known from time zero.
    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  tick_valid = 1'b0;
    logic signed [15:0]    tick_sp    = '0;
    logic signed [15:0]    tick_pos   = '0;
    logic                  cmd_ready  = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    // Pending ticks and predicted control results.
    t_tick  pending_ticks[$];
    t_drive expected_drives[$];

    // Controller model: register copy, tick phase and the stored error.
    t_cfg               cfg_model   = CFG_RESET;
    logic [7:0]         tick_phase  = '0;
    logic signed [16:0] held_error  = '0;
    longint             walk_err    = 0;

    int mismatch_count  = 0;
    int ticks_accepted  = 0;
    int updates_checked = 0;
    int settings_used   = 0;
    int snd_idle_pct    = 37;
    int rcv_idle_pct    = 47;
    bit tick_taken      = 1'b0;
    bit stall_req       = 1'b0;
    bit stall_ack       = 1'b0;
    int hold_left       = 0;

    fpc_in_if  tick_if ();
    fpc_out_if cmd_if ();

    assign tick_if.valid    = tick_valid;
    assign tick_if.setpoint = tick_sp;
    assign tick_if.position = tick_pos;
    assign cmd_if.ready     = cmd_ready;

    fuzzy_position_controller_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (tick_if),
        .o_out      (cmd_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Clock: 12 ns period.
    always begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    function automatic longint pick_min(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint pick_max(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    // Negative, zero and positive membership of x for inner breakpoint inner.
    // Shoulders saturate at the inner breakpoint, so the outer one never matters.
    function automatic void grade(input longint x, input longint inner,
                                  output longint g_neg, output longint g_zero,
                                  output longint g_pos);
        longint ax;
        longint slope;
        ax     = (x < 0) ? -x : x;
        slope  = (ax >= inner) ? FULL : (ax * FULL) / inner;
        g_zero = (ax >= inner) ? 0 : ((inner - ax) * FULL) / inner;
        g_neg  = (x < 0) ? slope : 0;
        g_pos  = (x > 0) ? slope : 0;
    endfunction

    // Advance the tick counter; on an update, queue the expected drive command.
    task automatic predict_tick(input logic signed [15:0] sp,
                                input logic signed [15:0] pos);
        int     next_cnt;
        longint err, rate;
        longint en, ez, ep, dn, dz, dp;
        longint r_neg, r_zero, r_pos, wsum, num, cv, mag, di, dout;
        t_drive cmd;
        next_cnt = int'(tick_phase) + 1;
        if (next_cnt < int'(cfg_model.ticks_per_update)) begin
            tick_phase = 8'(next_cnt);
            return;
        end
        tick_phase = '0;

        err        = longint'(sp) - longint'(pos);
        rate       = 100 * (err - longint'(held_error));
        held_error = err[16:0];

        grade(err, longint'(cfg_model.error_inner), en, ez, ep);
        grade(rate, longint'(cfg_model.rate_inner), dn, dz, dp);

        // Min/max rule base.
        r_neg  = pick_max(pick_min(dn, en), pick_min(dz, en));
        r_zero = pick_max(pick_max(pick_min(dp, en), pick_min(dn, ez)),
                          pick_max(pick_min(dz, ez), pick_min(dp, ez)));
        r_zero = pick_max(r_zero, pick_min(dn, ep));
        r_pos  = pick_max(pick_min(dz, ep), pick_min(dp, ep));
        wsum   = r_neg + r_zero + r_pos;

        // Weighted average; the centroids shift with this update's strengths.
        if (wsum == 0) begin
            cv = 0;
        end else begin
            di   = longint'(cfg_model.drive_inner);
            dout = longint'(cfg_model.drive_outer);
            num  = r_pos * (r_pos * di + dout * FULL) - r_neg * (r_neg * di + dout * FULL);
            cv   = num / (2 * FULL * wsum);
        end

        mag = (cv < 0) ? -cv : cv;
        if (mag > longint'(cfg_model.duty_limit)) begin
            mag = longint'(cfg_model.duty_limit);
        end
        cmd.duty          = mag[9:0];
        cmd.forward       = (cv > 0);
        cmd.control_value = cv[10:0];
        expected_drives.push_back(cmd);
    endtask

    task automatic note_mismatch(input string what, input t_drive want, input t_drive got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s: expected duty=%0d fwd=%0b cv=%0d, got duty=%0d fwd=%0b cv=%0d",
                     $time, what, want.duty, want.forward, $signed(want.control_value),
                     got.duty, got.forward, $signed(got.control_value));
        end
    endtask

    // Monitor: sample both channels at the rising edge.
    always @(posedge clk) begin : monitor
        t_drive got;
        t_drive want;
        tick_taken = rst_n && tick_valid && tick_if.ready;
        if (rst_n && cmd_if.valid && cmd_ready) begin
            got.duty          = cmd_if.duty;
            got.forward       = cmd_if.forward;
            got.control_value = cmd_if.control_value;
            if (expected_drives.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = expected_drives.pop_front();
                updates_checked++;
                if (got.duty !== want.duty || got.forward !== want.forward ||
                    got.control_value !== want.control_value) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
        if (tick_taken) begin
            ticks_accepted++;
            predict_tick(tick_sp, tick_pos);
        end
    end

    // Tick driver: holds a request until it is taken, then may idle.
    always @(negedge clk) begin : tick_driver
        if (tick_taken) begin
            void'(pending_ticks.pop_front());
        end
        if (tick_taken || !tick_valid) begin
            if (rst_n && pending_ticks.size() != 0 &&
                int'($urandom_range(99)) >= snd_idle_pct) begin
                tick_valid <= 1'b1;
                tick_sp    <= pending_ticks[0].setpoint;
                tick_pos   <= pending_ticks[0].position;
            end else begin
                tick_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(negedge clk) begin : result_receiver
        if (stall_req != stall_ack) begin
            stall_ack = stall_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            cmd_ready <= 1'b0;
        end else begin
            cmd_ready <= (int'($urandom_range(99)) >= rcv_idle_pct);
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
    endtask

    // Write every register; only called while the block is idle.
    task automatic load_settings(input t_cfg s);
        write_reg(REG_TICKS_PER_UPDATE, CFG_DATA_W'(s.ticks_per_update));
        write_reg(REG_ERROR_INNER, CFG_DATA_W'(s.error_inner));
        write_reg(REG_ERROR_OUTER, CFG_DATA_W'(s.error_outer));
        write_reg(REG_RATE_INNER, s.rate_inner);
        write_reg(REG_RATE_OUTER, s.rate_outer);
        write_reg(REG_DRIVE_INNER, CFG_DATA_W'(s.drive_inner));
        write_reg(REG_DRIVE_OUTER, CFG_DATA_W'(s.drive_outer));
        write_reg(REG_DUTY_LIMIT, CFG_DATA_W'(s.duty_limit));
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_model  = s;
        settings_used++;
    endtask

    // Wait for every tick to be taken and every result to arrive.
    task automatic settle();
        while (pending_ticks.size() != 0 || tick_valid || expected_drives.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_tick(input int sp, input int pos);
        t_tick t;
        t.setpoint = 16'(sp);
        t.position = 16'(pos);
        pending_ticks.push_back(t);
    endtask

    // Mostly a slowly wandering error inside the error sets, so memberships
    // and the derivative stay fractional; some jumps and fully random ticks.
    function automatic t_tick next_tick();
        int unsigned pick;
        logic [31:0] raw;
        longint      step, bound, lo, hi, pos, sp;
        t_tick       t;
        pick = $urandom_range(99);
        if (pick < 10) begin
            raw        = $urandom;
            t.setpoint = raw[15:0];
            raw        = $urandom;
            t.position = raw[15:0];
            return t;
        end
        bound = longint'(cfg_model.error_inner) * 3 / 2 + 1;
        if (pick < 15) begin
            walk_err = longint'($urandom_range(32'(2 * bound))) - bound;
        end else begin
            step = longint'(cfg_model.rate_inner) /
                   (100 * (longint'(cfg_model.ticks_per_update) + 1)) + 1;
            walk_err = walk_err + longint'($urandom_range(32'(2 * step))) - step;
        end
        if (walk_err > bound) begin
            walk_err = bound;
        end
        if (walk_err < -bound) begin
            walk_err = -bound;
        end
        lo  = (walk_err < 0) ? -32768 - walk_err : -32768;
        hi  = (walk_err > 0) ? 32767 - walk_err : 32767;
        pos = lo + longint'($urandom_range(32'(hi - lo)));
        sp  = pos + walk_err;
        t.position = pos[15:0];
        t.setpoint = sp[15:0];
        return t;
    endfunction

    function automatic t_cfg make_settings(input int max_period);
        t_cfg        s;
        int unsigned w;
        s.ticks_per_update = 8'($urandom_range(max_period, 1));
        w                  = $urandom_range(15, 1);
        s.error_inner      = 15'($urandom_range((1 << w) - 1, 1));
        s.error_outer      = 15'($urandom_range(32767, 2));
        w                  = $urandom_range(20, 1);
        s.rate_inner       = 20'($urandom_range((1 << w) - 1, 1));
        s.rate_outer       = 20'($urandom_range(1048575, 2));
        s.drive_inner      = 10'($urandom_range(1023));
        s.drive_outer      = 10'($urandom_range(1023));
        // Half the time a low limit, so the duty clamp is exercised.
        s.duty_limit       = ($urandom_range(1) != 0) ? 10'($urandom_range(1023))
                                                      : 10'($urandom_range(300));
        return s;
    endfunction

    task automatic run_random(input t_cfg s, input int count);
        load_settings(s);
        repeat (count) pending_ticks.push_back(next_tick());
        settle();
    endtask

    // Stimulus sequence.
    initial begin : stimulus
        t_cfg s;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Corners of error and derivative at one update per tick.
        s = CFG_RESET;
        s.ticks_per_update = 8'd1;
        load_settings(s);
        push_tick(0, 0);
        push_tick(5, 0);
        push_tick(6, 0);
        push_tick(3, 4);
        push_tick(0, 10);
        push_tick(0, 9);
        push_tick(11, 0);
        push_tick(32767, -32768);
        push_tick(-32768, 32767);
        push_tick(32767, 32767);
        push_tick(-32768, -32768);
        push_tick(-1, 0);
        push_tick(-2, 0);
        push_tick(1, 0);
        settle();

        // Period zero and zero-width sets: an all-zero error gives no weight.
        s.ticks_per_update = 8'd0;
        s.error_inner      = 15'd0;
        s.rate_inner       = 20'd0;
        load_settings(s);
        push_tick(0, 0);
        push_tick(0, 0);
        push_tick(7, 0);
        push_tick(-7, 0);
        push_tick(0, -1);
        settle();

        s = CFG_RESET;
        s.ticks_per_update = 8'd3;
        run_random(s, 60);
        run_random(make_settings(6), 60 + int'($urandom_range(9)));

        snd_idle_pct = 47;
        rcv_idle_pct = 37;
        s = '{8'd1, 15'd32767, 15'd32767, 20'hFFFFF, 20'hFFFFF, 10'd1023, 10'd1023, 10'd1023};
        run_random(s, 80);
        s = '{8'd1, 15'd1, 15'd2, 20'd1, 20'd2, 10'd0, 10'd0, 10'd0};
        run_random(s, 40);

        // Leave the counter mid-period, then lower the period.
        s = make_settings(8);
        s.ticks_per_update = 8'd8;
        run_random(s, 13);
        s = make_settings(3);
        s.ticks_per_update = 8'd2;
        run_random(s, 60);
        run_random(make_settings(6), 60);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;

        // Long receiver hold-off while ticks keep coming: the block backs up.
        s = make_settings(1);
        load_settings(s);
        stall_req = ~stall_req;
        repeat (30) pending_ticks.push_back(next_tick());
        settle();

        s = CFG_RESET;
        s.ticks_per_update = 8'd255;
        run_random(s, 260);
        run_random(make_settings(6), 30);

        $display("Run covered %0d ticks and %0d checked control updates over %0d settings,",
                 ticks_accepted, updates_checked, settings_used);
        $display("including update periods 0, 1 and 255, zero and full-scale breakpoints.");
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== fuzzy_position_controller_core.f =====
+incdir+hdl
hdl/fpc_pkg.sv
hdl/fpc_in_if.sv
hdl/fpc_out_if.sv
hdl/fpc_cfg_regs.sv
hdl/fpc_divider.sv
hdl/fuzzy_position_controller_core.sv
tb/fuzzy_position_controller_core_tb.sv
